// File: sv/lbpq_pkg.sv
package lbpq_pkg;

   localparam int NUM_BUCKETS_DEF = 1024;
   localparam int NUM_HANDLES_DEF = 1024;
   localparam int MAX_ENTRIES_DEF = 4096;

   localparam int FIELD_W = 10;

   localparam logic [1:0] REQ_INSERT   = 2'd0;
   localparam logic [1:0] REQ_POP      = 2'd1;
   localparam logic [1:0] REQ_CONTAINS = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [FIELD_W-1:0] handle;
      logic [FIELD_W-1:0] priority_req;
   } req_type_type;

   typedef struct packed {
      logic [FIELD_W-1:0] out_handle;
      logic               found;
      logic               in_queue;
      logic               queue_empty;
      logic               error_code;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch_req;
      logic clear_step;
      logic rd_bucket;
      logic rd_entry;
      logic do_insert;
      logic do_contains;
      logic pop_advance;
      logic pop_take;
      logic pop_none;
      logic ins_error;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic req_is_insert;
      logic req_is_pop;
      logic req_is_contains;
      logic ins_ok;
      logic count_zero;
      logic min_past_end;
      logic bucket_used;
      logic entry_valid;
   } sts_type;

endpackage

// File: sv/lbpq_ram.sv
module lbpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/lbpq_datapath.sv
module lbpq_datapath #(
   parameter int NUM_BUCKETS = lbpq_pkg::NUM_BUCKETS_DEF,
   parameter int NUM_HANDLES = lbpq_pkg::NUM_HANDLES_DEF,
   parameter int MAX_ENTRIES = lbpq_pkg::MAX_ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lbpq_pkg::req_type_type req_data,
   input  lbpq_pkg::cmd_type      cmd,
   output lbpq_pkg::sts_type      sts,
   output lbpq_pkg::rsp_type      rsp_data_in
);

   localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int HW = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
   localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int MW = $clog2(NUM_BUCKETS + 1);
   localparam int FW = lbpq_pkg::FIELD_W;
   localparam int CLRW = (NUM_BUCKETS > NUM_HANDLES) ? BW : HW;
   localparam int CLR_LAST = ((NUM_BUCKETS > NUM_HANDLES) ? NUM_BUCKETS : NUM_HANDLES) - 1;

   // Request latch.
   lbpq_pkg::req_type_type req_ff;

   // Scalar state.
   logic [EW-1:0]   free_head_ff;
   logic            free_any_ff;
   logic [CW-1:0]   next_unused_ff;
   logic [MW-1:0]   min_bucket_ff;
   logic [CW-1:0]   entry_count_ff;
   logic [CLRW-1:0] clr_ff;
   logic            clr_done_ff;

   // Memory ports. Bucket word: used, top. Mark word: set, bucket.
   logic            bk_we;
   logic [BW-1:0]   bk_wa, bk_ra;
   logic [EW:0]     bk_wd, bk_rd;
   logic            mk_we;
   logic [HW-1:0]   mk_wa, mk_ra;
   logic [BW:0]     mk_wd, mk_rd;
   logic            en_we;
   logic [EW-1:0]   en_wa, en_ra;
   logic [FW+EW:0]  en_wd, en_rd;

   logic [EW-1:0]   slot;
   logic            can_alloc;
   logic [BW-1:0]   cur_bucket;
   logic [FW-1:0]   ent_handle;
   logic [EW-1:0]   ent_link;
   logic            ent_last;
   logic            h_ok, p_ok;
   logic            mark_match;

   assign cur_bucket = min_bucket_ff[BW-1:0];
   assign ent_handle = en_rd[FW+EW:EW+1];
   assign ent_link   = en_rd[EW:1];
   assign ent_last   = en_rd[0];
   assign h_ok = ({{(32-FW){1'b0}}, req_ff.handle} < NUM_HANDLES);
   assign p_ok = ({{(32-FW){1'b0}}, req_ff.priority_req} < NUM_BUCKETS);
   assign can_alloc = free_any_ff || (next_unused_ff < CW'(MAX_ENTRIES));
   assign slot = free_any_ff ? free_head_ff : next_unused_ff[EW-1:0];

   // The mark read is taken at the popped entry's handle.
   assign mark_match = mk_rd[BW] && (mk_rd[BW-1:0] == cur_bucket) &&
                       ({{(32-FW){1'b0}}, ent_handle} < NUM_HANDLES);

   always_comb begin
      bk_ra = cmd.rd_bucket ? (req_ff.req_type == lbpq_pkg::REQ_INSERT ?
                               BW'(req_ff.priority_req) : cur_bucket) : cur_bucket;
      en_ra = free_any_ff && cmd.rd_bucket && req_ff.req_type == lbpq_pkg::REQ_INSERT ?
              free_head_ff : bk_rd[EW-1:0];
      mk_ra = cmd.rd_entry ? HW'(ent_handle) : HW'(req_ff.handle);
      bk_we = 1'b0;
      bk_wa = BW'(req_ff.priority_req);
      bk_wd = {1'b1, slot};
      mk_we = 1'b0;
      mk_wa = HW'(req_ff.handle);
      mk_wd = {1'b1, BW'(req_ff.priority_req)};
      en_we = 1'b0;
      en_wa = slot;
      en_wd = {req_ff.handle, bk_rd[EW-1:0], ~bk_rd[EW]};
      if (!clr_done_ff) begin
         bk_we = 1'b1;
         bk_wa = BW'(clr_ff);
         bk_wd = '0;
         mk_we = 1'b1;
         mk_wa = HW'(clr_ff);
         mk_wd = '0;
      end else if (cmd.do_insert && sts.ins_ok) begin
         bk_we = 1'b1;
         mk_we = 1'b1;
         en_we = 1'b1;
      end else if (cmd.pop_take) begin
         bk_we = 1'b1;
         bk_wa = cur_bucket;
         bk_wd = ent_last ? '0 : {1'b1, ent_link};
         en_we = 1'b1;
         en_wa = bk_rd[EW-1:0];
         en_wd = {ent_handle, free_head_ff, ~free_any_ff};
         mk_we = mark_match;
         mk_wa = HW'(ent_handle);
         mk_wd = '0;
      end
   end

   lbpq_ram #(.WIDTH(EW + 1), .DEPTH(NUM_BUCKETS)) u_bucket (
      .clock(clock), .wr_en(bk_we), .wr_addr(bk_wa), .wr_data(bk_wd),
      .rd_addr(bk_ra), .rd_data(bk_rd));

   lbpq_ram #(.WIDTH(BW + 1), .DEPTH(NUM_HANDLES)) u_mark (
      .clock(clock), .wr_en(mk_we), .wr_addr(mk_wa), .wr_data(mk_wd),
      .rd_addr(mk_ra), .rd_data(mk_rd));

   lbpq_ram #(.WIDTH(FW + EW + 1), .DEPTH(MAX_ENTRIES)) u_entry (
      .clock(clock), .wr_en(en_we), .wr_addr(en_wa), .wr_data(en_wd),
      .rd_addr(en_ra), .rd_data(en_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff   <= '0;
         free_any_ff    <= 1'b0;
         next_unused_ff <= '0;
         min_bucket_ff  <= MW'(NUM_BUCKETS);
         entry_count_ff <= '0;
         clr_ff         <= '0;
         clr_done_ff    <= 1'b0;
      end else begin
         if (!clr_done_ff) begin
            clr_ff <= clr_ff + CLRW'(1);
            if (clr_ff == CLRW'(CLR_LAST)) begin
               clr_done_ff <= 1'b1;
            end
         end
         if (cmd.do_insert && sts.ins_ok) begin
            if (free_any_ff) begin
               if (en_rd[0]) begin
                  free_any_ff <= 1'b0;
               end else begin
                  free_head_ff <= ent_link;
               end
            end else begin
               next_unused_ff <= next_unused_ff + CW'(1);
            end
            entry_count_ff <= entry_count_ff + CW'(1);
            if (MW'(req_ff.priority_req) < min_bucket_ff) begin
               min_bucket_ff <= MW'(req_ff.priority_req);
            end
         end
         if (cmd.pop_advance) begin
            min_bucket_ff <= min_bucket_ff + MW'(1);
         end
         if (cmd.pop_take) begin
            free_head_ff   <= bk_rd[EW-1:0];
            free_any_ff    <= 1'b1;
            entry_count_ff <= entry_count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff <= req_data;
      end
   end

   always_comb begin
      sts.clear_done      = clr_done_ff;
      sts.req_is_insert   = req_ff.req_type == lbpq_pkg::REQ_INSERT;
      sts.req_is_pop      = req_ff.req_type == lbpq_pkg::REQ_POP;
      sts.req_is_contains = req_ff.req_type == lbpq_pkg::REQ_CONTAINS;
      sts.ins_ok          = h_ok && p_ok && can_alloc;
      sts.count_zero      = entry_count_ff == '0;
      sts.min_past_end    = min_bucket_ff >= MW'(NUM_BUCKETS);
      sts.bucket_used     = bk_rd[EW];
      sts.entry_valid     = mark_match;
   end

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in.error_code = cmd.ins_error;
      if (cmd.do_contains) begin
         rsp_data_in.in_queue = h_ok && mk_rd[BW];
      end
      if (cmd.pop_take && mark_match) begin
         rsp_data_in.out_handle = ent_handle;
         rsp_data_in.found      = 1'b1;
      end
      if (cmd.pop_take) begin
         rsp_data_in.queue_empty = entry_count_ff == CW'(1);
      end else begin
         rsp_data_in.queue_empty = cmd.do_insert && sts.ins_ok ? 1'b0 : sts.count_zero;
      end
   end

endmodule

// File: sv/lbpq_ctrl.sv
module lbpq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  lbpq_pkg::rsp_type   rsp_data_in,
   output lbpq_pkg::rsp_type   rsp_data,
   input  lbpq_pkg::sts_type   sts,
   output lbpq_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_RD, ST_EXEC, ST_PRD, ST_PENT, ST_PCHK
   } state_type;

   state_type         state_ff, state_in;
   logic              rsp_valid_ff;
   lbpq_pkg::rsp_type rsp_data_ff;
   logic              emit;

   assign req_ready = (state_ff == ST_IDLE) && sts.clear_done && !rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      emit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.latch_req = req_ready;
            if (req_valid && req_ready) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            cmd.rd_bucket = 1'b1;
            if (sts.req_is_pop) begin
               if (sts.count_zero || sts.min_past_end) begin
                  cmd.pop_none = 1'b1;
                  emit = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_PRD;
               end
            end else begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.do_insert   = sts.req_is_insert;
            cmd.ins_error   = sts.req_is_insert && !sts.ins_ok;
            cmd.do_contains = sts.req_is_contains;
            emit = 1'b1;
            state_in = ST_IDLE;
         end
         ST_PRD: begin
            if (!sts.bucket_used) begin
               cmd.pop_advance = 1'b1;
               state_in = ST_RD;
            end else begin
               state_in = ST_PENT;
            end
         end
         ST_PENT: begin
            cmd.rd_entry = 1'b1;
            state_in = ST_PCHK;
         end
         ST_PCHK: begin
            cmd.pop_take = 1'b1;
            cmd.rd_entry = 1'b1;
            if (sts.entry_valid) begin
               emit = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      emit |-> !rsp_valid_ff) else $error("result overwritten");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("accept while busy");
   a_found_pop: assert property (@(posedge clock) disable iff (reset)
      (emit && rsp_data_in.found) |-> cmd.pop_take) else $error("found outside pop");

endmodule

// File: sv/lazy_bucket_priority_queue.sv
// Insert and contains pass the states RD and EXEC after acceptance; the result
// is registered at the end of EXEC. A pop on an empty queue answers from RD;
// else each empty bucket scanned passes RD and PRD, and each entry discarded
// or returned passes RD, PRD, PENT and PCHK, set by the single read port of each RAM.
// One request is in flight; the next is taken the cycle after the result has
// left. After reset a pass clears the bucket and mark memories.
module lazy_bucket_priority_queue #(
   parameter int NUM_BUCKETS = lbpq_pkg::NUM_BUCKETS_DEF,
   parameter int NUM_HANDLES = lbpq_pkg::NUM_HANDLES_DEF,
   parameter int MAX_ENTRIES = lbpq_pkg::MAX_ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lbpq_pkg::req_type_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lbpq_pkg::rsp_type      rsp_data
);

   lbpq_pkg::cmd_type cmd;
   lbpq_pkg::sts_type sts;
   lbpq_pkg::rsp_type rsp_data_in;

   lbpq_datapath #(
      .NUM_BUCKETS(NUM_BUCKETS), .NUM_HANDLES(NUM_HANDLES), .MAX_ENTRIES(MAX_ENTRIES)
   ) u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .cmd(cmd), .sts(sts),
      .rsp_data_in(rsp_data_in));

   lbpq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data_in(rsp_data_in),
      .rsp_data(rsp_data), .sts(sts), .cmd(cmd));

endmodule
